// File: rtl/core/hhd_pkg.sv
`timescale 1ns / 1ps
// Package for the heading hold distance drive core: payload types, status
// and register codes, reset values and fixed controller constants. No dependencies.
package hhd_pkg;

  localparam int AdcBits = 12;
  localparam int PotW    = 12;

  // status codes
  localparam logic [2:0] StatHold    = 3'd0;
  localparam logic [2:0] StatNew     = 3'd1;
  localparam logic [2:0] StatArrived = 3'd2;
  localparam logic [2:0] StatTimeout = 3'd3;
  localparam logic [2:0] StatSensor  = 3'd4;
  localparam logic [2:0] StatIdle    = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CfgTargetHeading = 3'd0;
  localparam logic [2:0] CfgBaseSpeed     = 3'd1;
  localparam logic [2:0] CfgTargetTravel  = 3'd2;
  localparam logic [2:0] CfgGainP         = 3'd3;
  localparam logic [2:0] CfgGainI         = 3'd4;
  localparam logic [2:0] CfgGainD         = 3'd5;
  localparam logic [2:0] CfgPeriod        = 3'd6;
  localparam logic [2:0] CfgTimeout       = 3'd7;

  localparam int CfgDataW = 24;

  // reset values
  localparam logic [15:0]       RstTargetHeading = 16'd18800;
  localparam logic signed [7:0] RstBaseSpeed     = 8'sd50;
  localparam logic [23:0]       RstTargetTravel  = 24'd63989;
  localparam logic [15:0]       RstGainP         = 16'd307;
  localparam logic [15:0]       RstGainI         = 16'd10;
  localparam logic [15:0]       RstGainD         = 16'd77;
  localparam logic [9:0]        RstPeriod        = 10'd20;
  localparam logic [21:0]       RstTimeout       = 22'd120000;

  // controller constants
  localparam int IntegralLimit = 10000000;
  localparam int CorrLimit     = 3500;
  localparam int PercentLimit  = 10000;
  localparam int HalfTurn      = 18000;
  localparam int FullTurn      = 36000;
  localparam int PScale        = 1000;
  localparam int DScale        = 1000000;
  localparam int DenScale      = 256000;
  localparam int Recip100      = 5243;  // ceil(2^19 / 100)
  localparam int Recip100Shift = 19;

  typedef struct packed {
    logic              operation;
    logic [PotW-1:0]   pot_right_a;
    logic [PotW-1:0]   pot_right_b;
    logic [PotW-1:0]   pot_left_a;
    logic [PotW-1:0]   pot_left_b;
    logic              samples_fresh;
    logic [15:0]       heading_cdeg;
    logic [9:0]        elapsed_ms;
    logic              sensors_ok;
  } hhd_in_t;

  typedef struct packed {
    logic signed [7:0] left_percent;
    logic signed [7:0] right_percent;
    logic [2:0]        status;
  } hhd_out_t;

endpackage

// File: rtl/core/hhd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the drive result.
// Depends on hhd_pkg for the payload types.
interface hhd_in_if;
  logic            valid;
  logic            ready;
  hhd_pkg::hhd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hhd_out_if;
  logic             valid;
  logic             ready;
  hhd_pkg::hhd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/heading_hold_distance_drive_core.sv
`timescale 1ns / 1ps
// Heading hold distance drive core: travel tracking, stop checks and a PID.
// Depends on hhd_pkg and the channel interfaces in hhd_if.sv.

// One item at a time. A start item, a sample while idle, or a timeout or sensor
// stop gives its result from the evaluate state; an arrival, or a sample with
// no control update due, gives it from the check state. In a control update, 8
// steps on one shared 34x33 multiplier build the PID numerator and denominator,
// a load state loads the divider, a radix-2 divider forms the 64-bit quotient
// bit by bit, then the CORR and PCT states clamp and scale the drive percents.
// The input is not ready from the transfer until the result has been taken.
module heading_hold_distance_drive_core #(
  parameter int ADC_BITS = hhd_pkg::AdcBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [hhd_pkg::CfgDataW-1:0] cfg_data_i,
  hhd_in_if.sink                       in_if,
  hhd_out_if.source                    out_if
);

  localparam int PW = (ADC_BITS < hhd_pkg::PotW) ? ADC_BITS : hhd_pkg::PotW;
  localparam int DW = ADC_BITS + 2;
  localparam logic signed [DW-1:0] Half = DW'((1 << (ADC_BITS - 1)) - 1);
  localparam logic signed [DW-1:0] Span = DW'(1 << ADC_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DLOAD = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_CORR  = 3'd6;
  localparam logic [2:0] ST_PCT   = 3'd7;

  localparam logic [2:0] MUL_LAST = 3'd7;

  // configuration
  logic [15:0]       tgt_hdg_q;
  logic signed [7:0] base_q;
  logic [23:0]       tgt_trv_q;
  logic [15:0]       kp_q, ki_q, kd_q;
  logic [9:0]        period_q;
  logic [21:0]       timeout_q;

  // drive state
  logic [2:0]               state_q;
  hhd_pkg::hhd_in_t         in_q;
  logic [PW-1:0]            last_pot_q [4];
  logic signed [31:0]       travel_q [4];
  logic signed [15:0]       last_err_q;
  logic signed [24:0]       integ_q, integ_n_q;
  logic [15:0]              ms_upd_q;
  logic [22:0]              ms_start_q;
  logic                     run_q;
  logic signed [7:0]        cmd_l_q, cmd_r_q;

  // PID datapath
  logic signed [15:0] e_q;
  logic signed [16:0] de_q;
  logic signed [33:0] x_q, tmp_q;
  logic signed [63:0] acc_q;
  logic [34:0]        den_q;
  logic [63:0]        dvd_q;
  logic [34:0]        rem_q;
  logic [5:0]         cnt_q;
  logic               neg_q;
  logic [2:0]         step_q;
  logic signed [14:0] lc_q, rc_q;

  logic             out_valid_q;
  hhd_pkg::hhd_out_t out_q;

  function automatic logic signed [15:0] wrap_err(input logic [15:0] t, input logic [15:0] h);
    logic signed [17:0] e;
    e = $signed({2'b00, t}) - $signed({2'b00, h});
    if (e > 18'(hhd_pkg::HalfTurn)) e = e - 18'(hhd_pkg::FullTurn);
    if (e > 18'(hhd_pkg::HalfTurn)) e = e - 18'(hhd_pkg::FullTurn);
    if (e < -18'sd18000) e = e + 18'(hhd_pkg::FullTurn);
    if (e < -18'sd18000) e = e + 18'(hhd_pkg::FullTurn);
    return e[15:0];
  endfunction

  function automatic logic signed [7:0] div100(input logic signed [14:0] v);
    logic [13:0] mag;
    logic [26:0] p;
    logic [7:0]  q;
    mag = v[14] ? 14'(-v) : v[13:0];
    p   = 27'(mag) * 27'(hhd_pkg::Recip100);
    q   = p[hhd_pkg::Recip100Shift +: 8];
    return v[14] ? -q : q;
  endfunction

  function automatic logic signed [14:0] clamp_pct(input logic signed [15:0] v);
    if (v > 16'sd10000) return 15'sd10000;
    if (v < -16'sd10000) return -15'sd10000;
    return v[14:0];
  endfunction

  // item evaluation terms
  logic [PW-1:0]      pot [4];
  logic signed [31:0] travel_n [4];
  logic [23:0]        ms_start_sum;
  logic [22:0]        ms_start_n;
  logic [16:0]        ms_upd_sum;
  logic [15:0]        ms_upd_n;
  logic signed [15:0] err_now;

  always_comb begin
    pot[0] = in_q.pot_right_a[PW-1:0];
    pot[1] = in_q.pot_right_b[PW-1:0];
    pot[2] = in_q.pot_left_a[PW-1:0];
    pot[3] = in_q.pot_left_b[PW-1:0];
    for (int i = 0; i < 4; i++) begin
      logic signed [DW-1:0] d;
      logic signed [32:0]   s;
      d = $signed(DW'(pot[i])) - $signed(DW'(last_pot_q[i]));
      if (d > Half) d = d - Span;
      if (d < -Half) d = d + Span;
      s = 33'(travel_q[i]) + 33'(d);
      if (s > 33'sh0_7FFF_FFFF) travel_n[i] = 32'sh7FFF_FFFF;
      else if (s < -33'sh0_8000_0000) travel_n[i] = 32'sh8000_0000;
      else travel_n[i] = s[31:0];
    end
    ms_start_sum = 24'(ms_start_q) + 24'(in_q.elapsed_ms);
    ms_start_n   = ms_start_sum[23] ? 23'h7F_FFFF : ms_start_sum[22:0];
    ms_upd_sum   = 17'(ms_upd_q) + 17'(in_q.elapsed_ms);
    ms_upd_n     = ms_upd_sum[16] ? 16'hFFFF : ms_upd_sum[15:0];
    err_now      = wrap_err(tgt_hdg_q, in_q.heading_cdeg);
  end

  // arrival and period checks
  logic [33:0] trv_right, trv_left;
  logic [24:0] need;
  logic [9:0]  period;
  logic        arrived;

  always_comb begin
    logic [32:0] a [4];
    for (int i = 0; i < 4; i++) begin
      a[i] = travel_q[i][31] ? 33'(-34'(travel_q[i])) : 33'(travel_q[i]);
    end
    trv_right = 34'(a[0]) + 34'(a[1]);
    trv_left  = 34'(a[2]) + 34'(a[3]);
    need      = {tgt_trv_q, 1'b0};
    arrived   = (trv_left >= 34'(need)) && (trv_right >= 34'(need));
    period    = (period_q == '0) ? 10'd1 : period_q;
  end

  // shared multiplier
  logic signed [33:0] mul_a;
  logic [31:0]        mul_b;
  logic signed [66:0] prod;

  always_comb begin
    unique case (step_q)
      3'd0: begin mul_a = 34'(e_q);       mul_b = 32'(ms_upd_q); end
      3'd1: begin mul_a = 34'(kp_q);      mul_b = 32'(hhd_pkg::PScale); end
      3'd2: begin mul_a = x_q;            mul_b = tmp_q[31:0]; end
      3'd3: begin mul_a = 34'(ki_q);      mul_b = 32'(ms_upd_q); end
      3'd4: begin mul_a = 34'(integ_n_q); mul_b = tmp_q[31:0]; end
      3'd5: begin mul_a = 34'(de_q);      mul_b = 32'(kd_q); end
      3'd6: begin mul_a = tmp_q;          mul_b = 32'(hhd_pkg::DScale); end
      default: begin mul_a = 34'(hhd_pkg::DenScale); mul_b = 32'(ms_upd_q); end
    endcase
    prod = mul_a * $signed({1'b0, mul_b});
  end

  logic signed [34:0] integ_sum;
  logic signed [24:0] integ_clamped;
  always_comb begin
    integ_sum = 35'(integ_q) + 35'(x_q);
    if (integ_sum > 35'(hhd_pkg::IntegralLimit)) integ_clamped = 25'(hhd_pkg::IntegralLimit);
    else if (integ_sum < -35'(hhd_pkg::IntegralLimit))
      integ_clamped = -25'(hhd_pkg::IntegralLimit);
    else integ_clamped = integ_sum[24:0];
  end

  // divider step
  logic [35:0] rem_sh;
  logic [35:0] rem_sub;
  logic        q_bit;
  always_comb begin
    rem_sh  = {rem_q, dvd_q[63]};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = rem_sh >= {1'b0, den_q};
  end

  // correction and side clamps
  logic               q_big;
  logic [11:0]        q_mag;
  logic signed [12:0] corr;
  logic signed [15:0] base100;
  always_comb begin
    q_big   = (|dvd_q[63:12]) || (dvd_q[11:0] > 12'(hhd_pkg::CorrLimit));
    q_mag   = q_big ? 12'(hhd_pkg::CorrLimit) : dvd_q[11:0];
    corr    = neg_q ? -13'(q_mag) : 13'(q_mag);
    base100 = 16'(base_q) * 16'sd100;
  end

  assign in_if.ready  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_hdg_q   <= hhd_pkg::RstTargetHeading;
      base_q      <= hhd_pkg::RstBaseSpeed;
      tgt_trv_q   <= hhd_pkg::RstTargetTravel;
      kp_q        <= hhd_pkg::RstGainP;
      ki_q        <= hhd_pkg::RstGainI;
      kd_q        <= hhd_pkg::RstGainD;
      period_q    <= hhd_pkg::RstPeriod;
      timeout_q   <= hhd_pkg::RstTimeout;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      in_q        <= '0;
      for (int i = 0; i < 4; i++) begin
        last_pot_q[i] <= '0;
        travel_q[i]   <= '0;
      end
      last_err_q <= '0;
      integ_q    <= '0;
      integ_n_q  <= '0;
      ms_upd_q   <= '0;
      ms_start_q <= '0;
      run_q      <= 1'b0;
      cmd_l_q    <= '0;
      cmd_r_q    <= '0;
      e_q        <= '0;
      de_q       <= '0;
      x_q        <= '0;
      tmp_q      <= '0;
      acc_q      <= '0;
      den_q      <= '0;
      dvd_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      neg_q      <= 1'b0;
      step_q     <= '0;
      lc_q       <= '0;
      rc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hhd_pkg::CfgTargetHeading: tgt_hdg_q <= cfg_data_i[15:0];
          hhd_pkg::CfgBaseSpeed:     base_q    <= cfg_data_i[7:0];
          hhd_pkg::CfgTargetTravel:  tgt_trv_q <= cfg_data_i[23:0];
          hhd_pkg::CfgGainP:         kp_q      <= cfg_data_i[15:0];
          hhd_pkg::CfgGainI:         ki_q      <= cfg_data_i[15:0];
          hhd_pkg::CfgGainD:         kd_q      <= cfg_data_i[15:0];
          hhd_pkg::CfgPeriod:        period_q  <= cfg_data_i[9:0];
          default:                   timeout_q <= cfg_data_i[21:0];
        endcase
      end

      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            in_q    <= in_if.data;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= ST_IDLE;
          if (!in_q.operation) begin
            out_valid_q <= 1'b1;
            out_q       <= '{8'sd0, 8'sd0,
                             in_q.sensors_ok ? hhd_pkg::StatNew : hhd_pkg::StatSensor};
            cmd_l_q     <= '0;
            cmd_r_q     <= '0;
            run_q       <= in_q.sensors_ok;
            if (in_q.sensors_ok) begin
              for (int i = 0; i < 4; i++) begin
                last_pot_q[i] <= pot[i];
                travel_q[i]   <= '0;
              end
              last_err_q <= err_now;
              integ_q    <= '0;
              ms_upd_q   <= '0;
              ms_start_q <= '0;
            end
          end else if (!run_q) begin
            out_valid_q <= 1'b1;
            out_q       <= '{8'sd0, 8'sd0, hhd_pkg::StatIdle};
          end else begin
            ms_start_q <= ms_start_n;
            ms_upd_q   <= ms_upd_n;
            if (ms_start_n >= 23'(timeout_q) || !in_q.sensors_ok) begin
              // abandon the drive
              out_valid_q <= 1'b1;
              out_q       <= '{8'sd0, 8'sd0, (ms_start_n >= 23'(timeout_q)) ?
                               hhd_pkg::StatTimeout : hhd_pkg::StatSensor};
              run_q       <= 1'b0;
              cmd_l_q     <= '0;
              cmd_r_q     <= '0;
            end else begin
              if (in_q.samples_fresh) begin
                for (int i = 0; i < 4; i++) begin
                  last_pot_q[i] <= pot[i];
                  travel_q[i]   <= travel_n[i];
                end
              end
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (arrived) begin
            out_valid_q <= 1'b1;
            out_q       <= '{8'sd0, 8'sd0, hhd_pkg::StatArrived};
            run_q       <= 1'b0;
            cmd_l_q     <= '0;
            cmd_r_q     <= '0;
            state_q     <= ST_IDLE;
          end else if (ms_upd_q >= 16'(period)) begin
            e_q     <= err_now;
            de_q    <= 17'(err_now) - 17'(last_err_q);
            acc_q   <= '0;
            step_q  <= '0;
            state_q <= ST_MUL;
          end else begin
            out_valid_q <= 1'b1;
            out_q       <= '{cmd_l_q, cmd_r_q, hhd_pkg::StatHold};
            state_q     <= ST_IDLE;
          end
        end
        ST_MUL: begin
          unique case (step_q)
            3'd0:    x_q   <= prod[33:0];
            3'd1: begin
              tmp_q     <= prod[33:0];
              integ_n_q <= integ_clamped;
            end
            3'd3, 3'd5: tmp_q <= prod[33:0];
            3'd7:    den_q <= prod[34:0];
            default: acc_q <= acc_q + prod[63:0];
          endcase
          step_q <= step_q + 3'd1;
          if (step_q == MUL_LAST) state_q <= ST_DLOAD;
        end
        ST_DLOAD: begin
          neg_q   <= acc_q[63];
          dvd_q   <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // shift one quotient bit in per cycle
          rem_q <= q_bit ? rem_sub[34:0] : rem_sh[34:0];
          dvd_q <= {dvd_q[62:0], q_bit};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'h3F) state_q <= ST_CORR;
        end
        ST_CORR: begin
          lc_q    <= clamp_pct(base100 + 16'(corr));
          rc_q    <= clamp_pct(base100 - 16'(corr));
          state_q <= ST_PCT;
        end
        default: begin
          cmd_l_q     <= div100(lc_q);
          cmd_r_q     <= div100(rc_q);
          integ_q     <= integ_n_q;
          last_err_q  <= e_q;
          ms_upd_q    <= '0;
          out_valid_q <= 1'b1;
          out_q       <= '{div100(lc_q), div100(rc_q), hhd_pkg::StatHold};
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/hhd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the heading hold distance drive core, bound to it.
// Depends on hhd_pkg and heading_hold_distance_drive_core.
module hhd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input hhd_pkg::hhd_out_t out_data_i
);

  // a result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  // one item at a time: no new transfer right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i && !out_valid_i)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.status <= hhd_pkg::StatIdle)
    else $error("status code out of range");

  // every status other than hold commands zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != hhd_pkg::StatHold |->
      out_data_i.left_percent == 8'sd0 && out_data_i.right_percent == 8'sd0)
    else $error("nonzero drive on a stop or idle result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.left_percent <= 8'sd100 &&
      out_data_i.left_percent >= -8'sd100 &&
      out_data_i.right_percent <= 8'sd100 && out_data_i.right_percent >= -8'sd100)
    else $error("drive percent beyond full scale");

endmodule

bind heading_hold_distance_drive_core hhd_checker u_hhd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
